// File: sv/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared constants, register codes and the types that link the match cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  // Pattern geometry.
  localparam int MaxPattern  = 32;
  localparam int LenW        = $clog2(MaxPattern + 1);
  localparam int PatRegs     = 4;
  localparam int BytesPerReg = 8;
  localparam int CfgDataW    = 64;
  localparam int CfgIdxW     = 3;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharAny  = 8'h3F;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPat0 = 3'd0,
    CfgPat1 = 3'd1,
    CfgPat2 = 3'd2,
    CfgPat3 = 3'd3,
    CfgLen  = 3'd4
  } cfg_reg_e;

  // Signals handed from one cell to its right neighbor.
  typedef struct packed {
    logic eff;    // current row bit (starting row when the row is fresh)
    logic nxt;    // row bit after the present text byte
    logic start;  // starting row bit
  } wpm_link_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic       fresh;  // row equals the starting row
    logic       adv;    // latch the next row bit
    logic [7:0] text;   // present text byte
  } wpm_ctrl_t;

endpackage

`default_nettype wire

// File: sv/wpm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds the match bit of one pattern prefix and computes its next value from
// the left neighbor's bits, the pattern byte and the text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell import wpm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire wpm_ctrl_t ctrl_i,
  input  wire logic [7:0] pat_char_i,
  input  wire wpm_link_t left_i,
  output wpm_link_t      right_o
);

  logic row_q;
  logic is_star;
  logic hit;
  logic start_bit;
  logic eff_bit;
  logic next_bit;

  // Decode the pattern byte.
  assign is_star = (pat_char_i == CharStar);
  assign hit     = (pat_char_i == CharAny) || (pat_char_i == ctrl_i.text);

  // A prefix of leading stars matches the empty text.
  assign start_bit = is_star & left_i.start;
  assign eff_bit   = ctrl_i.fresh ? start_bit : row_q;

  // A star extends from the left in the new row or holds from the old row;
  // other bytes take the diagonal bit on a hit.
  always_comb begin
    if (is_star) begin
      next_bit = left_i.nxt | eff_bit;
    end else if (hit) begin
      next_bit = left_i.eff;
    end else begin
      next_bit = 1'b0;
    end
  end

  // Row bit storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      row_q <= next_bit;
    end
  end

  assign right_o.eff   = eff_bit;
  assign right_o.nxt   = next_bit;
  assign right_o.start = start_bit;

endmodule

`default_nettype wire

// File: sv/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streams text bytes through a row of match cells, one cell per pattern byte.
// The result is registered and valid in the cycle after the final byte (or an
// empty text flag) is transferred. Text bytes are taken one per cycle while
// no held result stalls the input. Reset clears the pattern and length
// and loads the starting row; a write to a listed register reloads it too.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher import wpm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Text input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          text_char_i,
  input  wire logic                last_char_i,
  input  wire logic                empty_text_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     matched_o,
  // Configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0]          pat_q [PatRegs];
  logic [LenW-1:0]              len_q;
  logic [LenW-1:0]              len_eff;
  logic                         fresh_q;
  logic                         fresh_d;
  logic                         out_valid_q;
  logic                         out_valid_d;
  logic                         matched_q;
  logic                         matched_d;
  logic                         in_fire;
  logic                         cfg_fire;
  logic                         cfg_hit;
  logic                         result_fire;
  wpm_ctrl_t                    ctrl;
  wpm_link_t                    links [MaxPattern+1];
  logic [MaxPattern:0]          next_row;
  logic [MaxPattern:0]          start_row;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_fire & (cfg_index_i <= CfgLen);
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign result_fire = in_fire & (empty_text_i | last_char_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < PatRegs; r++) begin
        pat_q[r] <= '0;
      end
      len_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CfgPat0: pat_q[0] <= cfg_data_i;
        CfgPat1: pat_q[1] <= cfg_data_i;
        CfgPat2: pat_q[2] <= cfg_data_i;
        CfgPat3: pat_q[3] <= cfg_data_i;
        CfgLen:  len_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the row size use the full row.
  assign len_eff = (len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : len_q;

  // Cell control.
  assign ctrl.fresh = fresh_q;
  assign ctrl.adv   = in_fire & ~empty_text_i & ~last_char_i;
  assign ctrl.text  = text_char_i;

  // Prefix zero matches only while no byte has been taken.
  assign links[0].eff   = fresh_q;
  assign links[0].nxt   = 1'b0;
  assign links[0].start = 1'b1;
  assign next_row[0]    = 1'b0;
  assign start_row[0]   = 1'b1;

  // Row of match cells.
  for (genvar j = 1; j <= MaxPattern; j++) begin : g_cell
    wpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pat_char_i (pat_q[(j-1)/BytesPerReg][((j-1)%BytesPerReg)*8 +: 8]),
      .left_i     (links[j-1]),
      .right_o    (links[j])
    );
    assign next_row[j]  = links[j].nxt;
    assign start_row[j] = links[j].start;
  end

  // Row state: a result or a config write goes back to the starting row.
  always_comb begin
    fresh_d = fresh_q;
    if (cfg_hit || result_fire) begin
      fresh_d = 1'b1;
    end else if (ctrl.adv) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else begin
      fresh_q <= fresh_d;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    if (result_fire) begin
      out_valid_d = 1'b1;
      matched_d   = empty_text_i ? start_row[len_eff] : next_row[len_eff];
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // Checks.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_fire |=> out_valid_o)
    else $error("result transfer did not load the output register");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> fresh_q)
    else $error("config write did not restore the starting row");

  a_mid_byte_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.adv && !cfg_fire) |=> !fresh_q)
    else $error("middle byte left the row at the starting row");

  a_mid_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.adv && !out_valid_q) |=> !out_valid_o)
    else $error("middle byte produced a result");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Programs patterns with stars, any-byte marks and literals, streams texts
// through the matcher under several idle and stall mixes, and compares every
// match result with a cycle-free model of the match row kept in a scoreboard.
// ----------------------------------------------------------------------------

module testbench;
  import wpm_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 400;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 4;
  localparam int NumCfgRegs  = int'(CfgLen) + 1;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // Scoreboard: own copy of the pattern registers and the match row, plus
  // the queue of match bits still owed by the block.
  class match_scoreboard;
    logic [CfgDataW-1:0] pat_word [PatRegs];
    logic [LenW-1:0]     len_reg;
    bit [MaxPattern:0]   row;
    bit                  owed_q [$];
    int                  errors;
    int                  results_seen;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      len_reg = '0;
      row     = start_row();
    endfunction

    function int eff_len();
      return (len_reg > MaxPattern) ? MaxPattern : int'(len_reg);
    endfunction

    function logic [7:0] pat_byte(int j);
      return pat_word[j / BytesPerReg][(j % BytesPerReg) * 8 +: 8];
    endfunction

    // Bit 0 is set, and each leading star extends the run of set bits.
    function bit [MaxPattern:0] start_row();
      bit [MaxPattern:0] r;
      r = 1;
      for (int j = 1; j <= eff_len(); j++) begin
        if (pat_byte(j - 1) == CharStar) r[j] = r[j - 1];
      end
      return r;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Any write to a known register reloads the starting row.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx > CfgLen) return;
      if (idx == CfgLen) len_reg = data[LenW-1:0];
      else pat_word[idx] = data;
      row = start_row();
    endfunction

    // Advance the row by one accepted text item.
    function void note_input(logic [7:0] c, logic last, logic empty);
      bit [MaxPattern:0] nxt;
      bit [MaxPattern:0] st;
      logic [7:0]        p;
      int                n;
      n   = eff_len();
      st  = start_row();
      nxt = '0;
      if (empty) begin
        owed_q.push_back(st[n]);
        row = st;
        return;
      end
      for (int j = 1; j <= n; j++) begin
        p = pat_byte(j - 1);
        if (p == CharStar) nxt[j] = nxt[j - 1] | row[j];
        else if (p == CharAny || p == c) nxt[j] = row[j - 1];
        else nxt[j] = 1'b0;
      end
      if (last) begin
        owed_q.push_back(nxt[n]);
        row = st;
      end else begin
        row = nxt;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (owed_q.size() == 0) begin
        $error("unexpected result transfer: matched actual %b", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      results_seen++;
      if (got !== want) begin
        $error("matched: expected %0b, actual %b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          text_char_i;
  logic                last_char_i;
  logic                empty_text_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                matched_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wildcard_pattern_matcher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_char_i  (text_char_i),
    .last_char_i  (last_char_i),
    .empty_text_i (empty_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .matched_o    (matched_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  match_scoreboard sb;
  idle_mode_e      idle_mode;
  bit              hold_req;
  logic [7:0]      text_q [$];
  int              items_sent;
  int              cfg_writes;
  int              cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor: every result transfer is checked against the oldest owed bit.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_result(matched_o);
  end

  function automatic int idle_pct(bit receiver);
    case (idle_mode)
      IdleSender:   return receiver ? 0 : 54;
      IdleReceiver: return receiver ? 54 : 0;
      IdleBoth:     return 26;
      default:      return 0;
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) hold_left = HoldCycles;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  function automatic logic [7:0] rand_alpha();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'(8'h61 + $urandom_range(2));
  endfunction

  // Pattern word with mostly letters, plus stars, any-byte marks and odd bytes.
  function automatic logic [CfgDataW-1:0] rand_word();
    logic [CfgDataW-1:0] w;
    int                  r;
    for (int b = 0; b < BytesPerReg; b++) begin
      r = $urandom_range(99);
      if (r < 20) w[b*8 +: 8] = CharStar;
      else if (r < 35) w[b*8 +: 8] = CharAny;
      else if (r < 90) w[b*8 +: 8] = 8'(8'h61 + $urandom_range(2));
      else w[b*8 +: 8] = 8'($urandom_range(255));
    end
    return w;
  endfunction

  // One text item transfer, with random idle cycles ahead of it.
  task automatic send_item(logic [7:0] c, logic last, logic empty);
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    text_char_i  <= c;
    last_char_i  <= last;
    empty_text_i <= empty;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(c, last, empty);
    items_sent++;
  endtask

  // Whole text from text_q; an empty queue is sent as an empty-text flag.
  task automatic send_text();
    if (text_q.size() == 0) begin
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end else begin
      for (int i = 0; i < text_q.size(); i++) begin
        send_item(text_q[i], i == text_q.size() - 1, 1'b0);
      end
    end
  endtask

  // Sender pauses until every owed result is in, then lets the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes all four pattern words, then the length with random upper bits.
  task automatic program_pattern(logic [CfgDataW-1:0] w0, logic [CfgDataW-1:0] w1,
                                 logic [CfgDataW-1:0] w2, logic [CfgDataW-1:0] w3,
                                 int len);
    logic [CfgDataW-1:0] len_word;
    len_word            = {$urandom(), $urandom()};
    len_word[LenW-1:0]  = LenW'(len);
    write_cfg(CfgPat0, w0);
    write_cfg(CfgPat1, w1);
    write_cfg(CfgPat2, w2);
    write_cfg(CfgPat3, w3);
    write_cfg(CfgLen, len_word);
  endtask

  task automatic write_unused_regs();
    for (int k = NumCfgRegs; k < 2 ** CfgIdxW; k++)
      write_cfg(CfgIdxW'(k), {$urandom(), $urandom()});
  endtask

  // Random pattern; short lengths dominate, a few exceed the clamp.
  task automatic random_pattern();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 55) len = $urandom_range(8);
    else if (r < 85) len = $urandom_range(20, 9);
    else if (r < 95) len = $urandom_range(MaxPattern, 21);
    else len = $urandom_range(2 ** LenW - 1, MaxPattern + 1);
    r = $urandom_range(99);
    if (r < 5) program_pattern('1, '1, '1, '1, len);
    else if (r < 10) program_pattern({8{CharStar}}, {8{CharStar}}, {8{CharStar}},
                                     {8{CharStar}}, len);
    else program_pattern(rand_word(), rand_word(), rand_word(), rand_word(), len);
    if ($urandom_range(4) == 0)
      write_cfg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, NumCfgRegs)),
                {$urandom(), $urandom()});
  endtask

  // Text built to fit the pattern, sometimes with one byte changed.
  task automatic build_matching_text();
    logic [7:0] p;
    text_q.delete();
    for (int j = 0; j < sb.eff_len(); j++) begin
      p = sb.pat_byte(j);
      if (p == CharStar) repeat ($urandom_range(3)) text_q.push_back(rand_alpha());
      else if (p == CharAny) text_q.push_back(rand_alpha());
      else text_q.push_back(p);
    end
    if (text_q.size() > 0 && $urandom_range(99) < 30)
      text_q[$urandom_range(text_q.size() - 1)] = rand_alpha();
  endtask

  task automatic build_random_text(bit full);
    text_q.delete();
    repeat ($urandom_range(8)) text_q.push_back(full ? 8'($urandom_range(255)) : rand_alpha());
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int kind;
    int since_cfg;
    int goal;
    in_valid_i   = 1'b0;
    text_char_i  = '0;
    last_char_i  = 1'b0;
    empty_text_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    hold_req     = 1'b0;
    idle_mode    = IdleNone;
    sb           = new();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pattern after reset: only the empty text matches.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    wait_idle();

    // Single star: both flags set means an empty text, and a star byte is no literal.
    program_pattern({56'h0, CharStar}, '0, '0, '0, 1);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(CharStar, 1'b1, 1'b0);
    wait_idle();

    // Mixed pattern a?*b, an empty-text flag mid-text, and a text left unfinished.
    program_pattern({32'h0, 8'h62, CharStar, CharAny, 8'h61}, '0, '0, '0, 4);
    text_q = '{8'h61, 8'h78, 8'h62};
    send_text();
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    text_q = '{8'h61, CharAny, 8'h63, 8'h63, 8'h62};
    send_text();
    send_item(8'h61, 1'b0, 1'b0);
    wait_idle();

    // All-ones pattern with a length above the clamp.
    program_pattern('1, '1, '1, '1, 2 ** LenW - 1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    wait_idle();

    // Full-length pattern of stars, then writes to unused indexes.
    program_pattern({8{CharStar}}, {8{CharStar}}, {8{CharStar}}, {8{CharStar}}, MaxPattern);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    wait_idle();
    write_unused_regs();
    send_item(8'h3C, 1'b1, 1'b1);
    wait_idle();

    // Zero bytes as literals.
    program_pattern('0, '0, '0, '0, 2);
    text_q = '{8'h00, 8'h00};
    send_text();
    wait_idle();

    // Random phases, one per idle mix.
    for (int m = IdleNone; m <= IdleBoth; m++) begin
      idle_mode = idle_mode_e'(m);
      goal      = items_sent + RandomItems / 4;
      since_cfg = 99;
      while (items_sent < goal) begin
        if (since_cfg > 6) begin
          wait_idle();
          random_pattern();
          since_cfg = $urandom_range(3);
        end
        kind = $urandom_range(99);
        if (kind < 60) begin
          build_matching_text();
          send_text();
        end else if (kind < 75) begin
          build_random_text(1'b0);
          send_text();
        end else if (kind < 85) begin
          text_q.delete();
          send_text();
        end else if (kind < 92) begin
          build_random_text(1'b1);
          send_text();
        end else begin
          // Broken text: cut short by an empty flag, or dropped by a new pattern.
          build_matching_text();
          foreach (text_q[k]) send_item(text_q[k], 1'b0, 1'b0);
          if (kind < 96) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          else since_cfg = 99;
        end
        since_cfg++;
      end
      wait_idle();

      // Long result hold-off while short texts keep coming.
      if (idle_mode == IdleNone) begin
        hold_req = 1'b1;
        repeat (30) send_item(rand_alpha(), 1'b1, $urandom_range(3) == 0);
        wait_idle();
      end
    end

    $display("Checked %0d match results from %0d text items and %0d register writes.",
             sb.results_seen, items_sent, cfg_writes);
    $display("Ran four idle mixes, one long result hold-off and lengths past the clamp.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
